/* sv/cws_pkg.sv */
package cws_pkg;

  // sample format and fixed-point layout
  localparam int SAMPLE_BITS   = 16;
  localparam int FRAC_BITS     = SAMPLE_BITS - 1;
  localparam int COEF_FRAC     = 12;
  localparam int OUT_SHIFT     = FRAC_BITS - COEF_FRAC;

  // harmonic and coefficient counts
  localparam int MAX_HARMONICS = 9;
  localparam int COEF_CNT      = MAX_HARMONICS + 1;
  localparam int IDX_W         = 4;
  localparam int HARM_W        = 4;

  // datapath widths
  localparam int WEIGHT_W      = 16;
  localparam int DELTA_W       = WEIGHT_W + 1;
  localparam int COEF_W        = 26;
  localparam int ACC_W         = 29;
  localparam int MB_W          = 17;
  localparam int PROD_W        = ACC_W + MB_W;
  localparam int Y_W           = ACC_W + OUT_SHIFT;
  localparam int TC_W          = 11;

  // stream payload widths
  localparam int S_TDATA_W     = 40;
  localparam int M_TDATA_W     = 16;

  // item kinds carried on tuser
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_WEIGHT = 1'b1;

  // power-series coefficients of T1..T9, row = harmonic - 1, column = power of x
  localparam logic signed [TC_W-1:0] CHEB_TBL [MAX_HARMONICS][COEF_CNT] = '{
    '{ 11'sd0,  11'sd1,   11'sd0,   11'sd0,    11'sd0,   11'sd0,
       11'sd0,  11'sd0,   11'sd0,   11'sd0},
    '{-11'sd1,  11'sd0,   11'sd2,   11'sd0,    11'sd0,   11'sd0,
       11'sd0,  11'sd0,   11'sd0,   11'sd0},
    '{ 11'sd0, -11'sd3,   11'sd0,   11'sd4,    11'sd0,   11'sd0,
       11'sd0,  11'sd0,   11'sd0,   11'sd0},
    '{ 11'sd1,  11'sd0,  -11'sd8,   11'sd0,    11'sd8,   11'sd0,
       11'sd0,  11'sd0,   11'sd0,   11'sd0},
    '{ 11'sd0,  11'sd5,   11'sd0,  -11'sd20,   11'sd0,   11'sd16,
       11'sd0,  11'sd0,   11'sd0,   11'sd0},
    '{-11'sd1,  11'sd0,   11'sd18,  11'sd0,   -11'sd48,  11'sd0,
       11'sd32, 11'sd0,   11'sd0,   11'sd0},
    '{ 11'sd0, -11'sd7,   11'sd0,   11'sd56,   11'sd0,  -11'sd112,
       11'sd0,  11'sd64,  11'sd0,   11'sd0},
    '{ 11'sd1,  11'sd0,  -11'sd32,  11'sd0,    11'sd160, 11'sd0,
      -11'sd256, 11'sd0,  11'sd128, 11'sd0},
    '{ 11'sd0,  11'sd9,   11'sd0,  -11'sd120,  11'sd0,   11'sd432,
       11'sd0, -11'sd576, 11'sd0,   11'sd256}
  };

  // commands from controller to datapath
  typedef struct packed {
    logic             load;
    logic             upd_mul;
    logic             upd_add;
    logic             hor_mul;
    logic             hor_add;
    logic             out_load;
    logic [IDX_W-1:0] idx;
  } cws_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic kind;
    logic h_ok;
  } cws_sts_t;

endpackage

/* sv/cws_ctrl.sv */
module cws_ctrl import cws_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_axis_tvalid,
  output logic     s_axis_tready,
  output logic     m_axis_tvalid,
  input  logic     m_axis_tready,
  input  cws_sts_t sts_i,
  output cws_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_UPD_MUL = 3'd1;
  localparam logic [2:0] S_UPD_ADD = 3'd2;
  localparam logic [2:0] S_HOR_MUL = 3'd3;
  localparam logic [2:0] S_HOR_ADD = 3'd4;
  localparam logic [2:0] S_OUT     = 3'd5;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(COEF_CNT - 1);
  localparam logic [IDX_W-1:0] IDX_TOP  = IDX_W'(COEF_CNT - 2);

  logic [2:0]       state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             m_valid_q, m_valid_d;
  logic             accept;
  logic             out_free;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;

  // next state and step counter
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (sts_i.kind == KIND_SAMPLE) begin
            state_d = S_HOR_MUL;
            idx_d   = IDX_TOP;
          end else if (sts_i.h_ok) begin
            state_d = S_UPD_MUL;
            idx_d   = '0;
          end
        end
      end
      S_UPD_MUL: state_d = S_UPD_ADD;
      S_UPD_ADD: begin
        if (idx_q == IDX_LAST) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_UPD_MUL;
          idx_d   = idx_q + 1'b1;
        end
      end
      S_HOR_MUL: state_d = S_HOR_ADD;
      S_HOR_ADD: begin
        if (idx_q == '0) begin
          state_d = S_OUT;
        end else begin
          state_d = S_HOR_MUL;
          idx_d   = idx_q - 1'b1;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // commands to the datapath
  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = accept;
    cmd_o.upd_mul  = (state_q == S_UPD_MUL);
    cmd_o.upd_add  = (state_q == S_UPD_ADD);
    cmd_o.hor_mul  = (state_q == S_HOR_MUL);
    cmd_o.hor_add  = (state_q == S_HOR_ADD);
    cmd_o.out_load = (state_q == S_OUT) && out_free;
    cmd_o.idx      = idx_q;
  end

  // output request flag
  always_comb begin
    m_valid_d = m_valid_q;
    if (cmd_o.out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      idx_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      m_valid_q <= m_valid_d;
    end
  end

  // a sample request starts the polynomial evaluation
  a_sample_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && sts_i.kind == KIND_SAMPLE |=> state_q == S_HOR_MUL && idx_q == IDX_TOP)
    else $error("sample request did not start evaluation");

  // the last horner step hands over to the output stage
  a_horner_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_HOR_ADD && idx_q == '0 |=> state_q == S_OUT)
    else $error("horner evaluation did not end in output stage");

  // a result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> out_free)
    else $error("output register overwritten");

  // a new result appears only out of the output stage
  a_valid_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q) == S_OUT)
    else $error("result raised outside output stage");

endmodule

/* sv/cws_datapath.sv */
module cws_datapath import cws_pkg::*; #(
  parameter int NUM_HARMONICS = MAX_HARMONICS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [S_TDATA_W-1:0]   s_axis_tdata,
  input  logic                   s_axis_tuser,
  output logic [M_TDATA_W-1:0]   m_axis_tdata,
  output logic                   m_axis_tuser,
  input  cws_cmd_t               cmd_i,
  output cws_sts_t               sts_o
);

  localparam int HIDX_W = (NUM_HARMONICS > 1) ? $clog2(NUM_HARMONICS) : 1;
  localparam logic signed [Y_W-1:0] Y_HI = Y_W'((64'sd1 <<< FRAC_BITS) - 1);
  localparam logic signed [Y_W-1:0] Y_LO = -Y_W'(64'sd1 <<< FRAC_BITS);

  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic        [HARM_W-1:0]      in_harm;
  logic signed [WEIGHT_W-1:0]    in_weight;

  logic signed [WEIGHT_W-1:0]    weight_q [NUM_HARMONICS];
  logic signed [COEF_W-1:0]      coef_q   [COEF_CNT];
  logic signed [SAMPLE_BITS-1:0] x_q;
  logic        [HARM_W-1:0]      h_q;
  logic signed [DELTA_W-1:0]     delta_q;
  logic signed [ACC_W-1:0]       acc_q;
  logic signed [PROD_W-1:0]      prod_q;
  logic signed [M_TDATA_W-1:0]   out_q;
  logic                          clip_q;

  logic signed [ACC_W-1:0]       mul_a;
  logic signed [MB_W-1:0]        mul_b;
  logic signed [COEF_W-1:0]      coef_rd;
  logic signed [ACC_W-1:0]       acc_next;
  logic signed [Y_W-1:0]         y_full;
  logic signed [M_TDATA_W-1:0]   y_sat;
  logic                          y_clip;

  // unpack request fields, sample at the bottom
  assign in_sample = s_axis_tdata[SAMPLE_BITS-1:0];
  assign in_harm   = s_axis_tdata[SAMPLE_BITS +: HARM_W];
  assign in_weight = s_axis_tdata[SAMPLE_BITS+HARM_W +: WEIGHT_W];

  assign sts_o.kind = s_axis_tuser;
  assign sts_o.h_ok = (in_harm < HARM_W'(NUM_HARMONICS));

  assign coef_rd = coef_q[cmd_i.idx];

  // shared multiplier operands: weight change times table entry, or acc times x
  always_comb begin
    if (cmd_i.upd_mul) begin
      mul_a = ACC_W'(delta_q);
      mul_b = MB_W'(CHEB_TBL[h_q][cmd_i.idx]);
    end else begin
      mul_a = acc_q;
      mul_b = MB_W'(x_q);
    end
  end

  // horner step: floor of product by 2^F plus next coefficient
  assign acc_next = prod_q[FRAC_BITS +: ACC_W] + ACC_W'(coef_rd);

  // scale Q.12 to the sample format and saturate
  always_comb begin
    y_full = Y_W'(acc_q) <<< OUT_SHIFT;
    y_clip = 1'b0;
    y_sat  = y_full[M_TDATA_W-1:0];
    if (y_full > Y_HI) begin
      y_sat  = Y_HI[M_TDATA_W-1:0];
      y_clip = 1'b1;
    end else if (y_full < Y_LO) begin
      y_sat  = Y_LO[M_TDATA_W-1:0];
      y_clip = 1'b1;
    end
  end

  // weight and coefficient state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_HARMONICS; i++) begin
        weight_q[i] <= '0;
      end
      for (int j = 0; j < COEF_CNT; j++) begin
        coef_q[j] <= '0;
      end
    end else begin
      if (cmd_i.load && s_axis_tuser == KIND_WEIGHT && sts_o.h_ok) begin
        weight_q[in_harm[HIDX_W-1:0]] <= in_weight;
      end
      if (cmd_i.upd_add) begin
        coef_q[cmd_i.idx] <= coef_rd + prod_q[COEF_W-1:0];
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q     <= in_sample;
      h_q     <= in_harm;
      delta_q <= DELTA_W'(in_weight) - DELTA_W'(weight_q[in_harm[HIDX_W-1:0]]);
      acc_q   <= ACC_W'(coef_q[COEF_CNT-1]);
    end else if (cmd_i.hor_add) begin
      acc_q   <= acc_next;
    end
    if (cmd_i.upd_mul || cmd_i.hor_mul) begin
      prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
    if (cmd_i.out_load) begin
      out_q  <= y_sat;
      clip_q <= y_clip;
    end
  end

  assign m_axis_tdata = out_q;
  assign m_axis_tuser = clip_q;

  // a saturated result is always flagged
  a_sat_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load && (y_full > Y_HI || y_full < Y_LO) |=> clip_q)
    else $error("saturated result not flagged");

  // a result without clipping carries the scaled accumulator unchanged
  a_no_clip_exact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load && !y_clip |=> out_q == $past(y_full[M_TDATA_W-1:0]))
    else $error("unclipped result altered");

  // weight entry zero only changes on a weight request
  a_weight_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.load && s_axis_tuser == KIND_WEIGHT) |=> $stable(weight_q[0]))
    else $error("weight changed without a weight request");

endmodule

/* sv/chebyshev_waveshaper.sv */
// channel   dir  tdata (low bit up)                          tuser
// s_axis    in   sample[15:0] harmonic[19:16] weight[35:20]  kind (0 sample, 1 weight)
// m_axis    out  shaped_sample[15:0]                         clipped
//
// one shared 29x17 multiplier carries all multiplications; each step is a multiply state, then an add state
// sample request: accept, nine horner steps from the top coefficient down, then the output stage
// weight request: accept, then ten coefficient updates
// a weight request for an unused harmonic is accepted and then dropped
// reset clears weights and coefficients, so samples shape to zero until a weight is set
// a result waits in the output register while the next request runs; a second result
// then holds the output stage, and no request is taken until the first one leaves
module chebyshev_waveshaper import cws_pkg::*; #(
  parameter int NUM_HARMONICS = MAX_HARMONICS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // sample[15:0], harmonic[19:16], weight[35:20], zero[39:36]
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // kind
  input  logic                 s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // shaped_sample[15:0]
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // clipped
  output logic                 m_axis_tuser
);

  cws_cmd_t cmd;
  cws_sts_t sts;

  // sequencer
  cws_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  // coefficient store, multiplier and output stage
  cws_datapath #(
    .NUM_HARMONICS (NUM_HARMONICS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

endmodule

/* tb/sv/cws_checker.sv */
module cws_checker import cws_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  input  logic                 req_ready_i,
  // sample[15:0], harmonic[19:16], weight[35:20], zero[39:36]
  input  logic [S_TDATA_W-1:0] req_data_i,
  // kind
  input  logic                 req_kind_i,
  input  logic                 res_valid_i,
  input  logic                 res_ready_i,
  // shaped_sample[15:0]
  input  logic [M_TDATA_W-1:0] res_data_i,
  // clipped
  input  logic                 res_clipped_i,
  output int                   mismatches_o,
  output int                   outstanding_o
);

  typedef struct packed {
    logic [M_TDATA_W-1:0] shaped;
    logic                 clipped;
  } shaped_res_t;

  // mirrored harmonic gains and the polynomial they add up to
  logic signed [WEIGHT_W-1:0] gain [MAX_HARMONICS];
  longint                     series [COEF_CNT];
  shaped_res_t                shaped_q [$];
  int                         mismatches;

  assign mismatches_o  = mismatches;
  assign outstanding_o = shaped_q.size();

  task automatic report(input string what, input longint got, input longint want);
    $display("cws_checker: %s mismatch, got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  // expand the weighted T1..T9 sum into powers of x
  function automatic void rebuild_power_series();
    longint g [MAX_HARMONICS];
    for (int i = 0; i < MAX_HARMONICS; i++) g[i] = longint'(gain[i]);
    series[0] = -g[1] + g[3] - g[5] + g[7];
    series[1] = g[0] - 3 * g[2] + 5 * g[4] - 7 * g[6] + 9 * g[8];
    series[2] = 2 * g[1] - 8 * g[3] + 18 * g[5] - 32 * g[7];
    series[3] = 4 * g[2] - 20 * g[4] + 56 * g[6] - 120 * g[8];
    series[4] = 8 * g[3] - 48 * g[5] + 160 * g[7];
    series[5] = 16 * g[4] - 112 * g[6] + 432 * g[8];
    series[6] = 32 * g[5] - 256 * g[7];
    series[7] = 64 * g[6] - 576 * g[8];
    series[8] = 128 * g[7];
    series[9] = 256 * g[8];
  endfunction

  // horner evaluation in q.12, then scale to the sample format and saturate
  function automatic shaped_res_t shape_sample(input logic signed [SAMPLE_BITS-1:0] x);
    shaped_res_t r;
    longint      acc;
    longint      y;
    longint      top;
    longint      bottom;
    top    = (longint'(1) <<< FRAC_BITS) - 1;
    bottom = -(longint'(1) <<< FRAC_BITS);
    acc = series[COEF_CNT-1];
    for (int k = COEF_CNT - 2; k >= 0; k--)
      acc = ((acc * longint'(x)) >>> FRAC_BITS) + series[k];
    y = acc <<< OUT_SHIFT;
    r.clipped = 1'b0;
    if (y > top) begin
      y = top;
      r.clipped = 1'b1;
    end
    if (y < bottom) begin
      y = bottom;
      r.clipped = 1'b1;
    end
    r.shaped = y[M_TDATA_W-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    shaped_res_t want;
    logic [HARM_W-1:0] harm;
    if (!rst_ni) begin
      for (int i = 0; i < MAX_HARMONICS; i++) gain[i] = '0;
      for (int i = 0; i < COEF_CNT; i++) series[i] = 0;
      shaped_q.delete();
      mismatches = 0;
    end else begin
      // results first: they belong to older requests
      if (res_valid_i && res_ready_i) begin
        if (shaped_q.size() == 0) begin
          report("unexpected result", $signed(res_data_i), 0);
        end else begin
          want = shaped_q.pop_front();
          if (res_data_i !== want.shaped)
            report("shaped_sample", $signed(res_data_i), $signed(want.shaped));
          if (res_clipped_i !== want.clipped)
            report("clipped", res_clipped_i, want.clipped);
        end
      end
      // accepted request: update gains or queue the shaped sample
      if (req_valid_i && req_ready_i) begin
        if (req_kind_i == KIND_WEIGHT) begin
          harm = req_data_i[19:16];
          if (harm < MAX_HARMONICS) begin
            gain[harm] = req_data_i[35:20];
            rebuild_power_series();
          end
        end else begin
          shaped_q.push_back(shape_sample(req_data_i[SAMPLE_BITS-1:0]));
        end
      end
    end
  end

endmodule

/* tb/sv/tb.sv */
module tb import cws_pkg::*; ();

  localparam int CYCLE_LIMIT = 300000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic                 s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tuser;
  int                   mismatches;
  int                   outstanding;
  int                   cycle_cnt = 0;
  int                   burst_left;
  int                   ready_mode = 0;
  logic [7:0]           ready_pattern = 8'hff;

  chebyshev_waveshaper uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  cws_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (s_axis_tvalid),
    .req_ready_i  (s_axis_tready),
    .req_data_i   (s_axis_tdata),
    .req_kind_i   (s_axis_tuser),
    .res_valid_i  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_data_i   (m_axis_tdata),
    .res_clipped_i(m_axis_tuser),
    .mismatches_o (mismatches),
    .outstanding_o(outstanding)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // result side stalls, switching among four randomly picked styles
  always @(posedge clk_i) begin
    if (cycle_cnt % 64 == 0) begin
      ready_mode    <= $urandom_range(0, 3);
      ready_pattern <= $urandom_range(1, 255);
    end
    case (ready_mode)
      0: begin
        m_axis_tready <= 1'b1;
      end
      1: begin
        m_axis_tready <= ready_pattern[cycle_cnt[2:0]];
      end
      2: begin
        m_axis_tready <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        m_axis_tready <= ($urandom_range(0, 5) == 0);
      end
    endcase
  end

  // one request, with bursts and gaps between them; called at a rising edge
  task automatic push_request(input logic kind, input logic [15:0] sample,
                              input logic [3:0] harm, input logic [15:0] weight);
    int  gap;
    logic hit;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 10);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {4'b0, weight, harm, sample};
    do begin
      @(negedge clk_i);
      hit = s_axis_tready;
      @(posedge clk_i);
    end while (!hit);
  endtask

  task automatic shape(input logic [15:0] sample);
    push_request(KIND_SAMPLE, sample, 4'($urandom), 16'($urandom));
  endtask

  task automatic set_gain(input logic [3:0] harm, input logic [15:0] weight);
    push_request(KIND_WEIGHT, 16'($urandom), harm, weight);
  endtask

  initial begin
    int  pick;
    logic [3:0] harm;
    logic [15:0] weight;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = KIND_SAMPLE;
    burst_left    = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // all gains zero after reset: everything shapes to zero
    shape(16'h7fff);
    shape(16'h8000);
    // harmonics past the ninth are ignored
    set_gain(4'd9, 16'h7fff);
    set_gain(4'd15, 16'h8000);
    shape(16'h4000);
    // unity fundamental, then full-scale gains; the positive one drives the output to clipping
    set_gain(4'd0, 16'd4096);
    shape(16'h7fff);
    shape(16'h8000);
    set_gain(4'd0, 16'h7fff);
    shape(16'h7fff);
    shape(16'h8000);
    set_gain(4'd0, 16'h8000);
    shape(16'h0001);
    shape(16'hffff);
    // every higher harmonic, alternating sign
    set_gain(4'd0, 16'd0);
    for (int h = 1; h < MAX_HARMONICS; h++)
      set_gain(4'(h), (h % 2 == 1) ? 16'd1024 : 16'hfc00);
    shape(16'h7fff);
    shape(16'h8000);
    shape(16'h0000);
    shape(16'h3039);

    // random mix, mostly samples, gains mostly within plus or minus unity
    for (int n = 0; n < 500; n++) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        shape(16'($urandom));
      end else begin
        harm   = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                               : 4'($urandom_range(0, 8));
        weight = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                              : 16'($urandom_range(0, 8192) - 4096);
        set_gain(harm, weight);
      end
    end
    s_axis_tvalid <= 1'b0;

    // let the checker queue the last request, drain, then let the block settle
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
